/* rtl/http2d_pkg.sv */
// Shared types, codes and constants for the HTTP/2 receive deframer.
// Used by http2d_core and the top level; depends on nothing.
`default_nettype none

package http2d_pkg;

  localparam int unsigned PREFACE_LEN = 24;
  localparam int unsigned HEADER_LEN  = 9;

  localparam logic [7:0]  TYPE_DATA     = 8'h00;
  localparam logic [7:0]  TYPE_SETTINGS = 8'h04;
  localparam logic [7:0]  FLAG_ACK      = 8'h01;

  localparam logic [23:0] MAX_FRAME_RST   = 24'd16384;
  localparam logic [30:0] INIT_WINDOW_RST = 31'd65535;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_FRAME   = 2'd0,
    CFG_INIT_WINDOW = 2'd1,
    CFG_EXPECT_PRE  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_ABSORB  = 3'd0,
    KIND_HEADER  = 3'd1,
    KIND_PAYLOAD = 3'd2,
    KIND_ACK     = 3'd3,
    KIND_ERROR   = 3'd4,
    KIND_DROP    = 3'd5,
    KIND_PREFACE = 3'd6
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_FRAME     = 2'd1,
    ERR_FLOW      = 2'd2,
    ERR_PREFACE   = 2'd3
  } err_t;

  // configuration write word
  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [30:0] data;
  } cfg_wr_t;

  // one result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [23:0] frm_length;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_flag_bits;
    logic [30:0] stream_number;
    logic [30:0] win_update;
    err_t        fault_code;
  } result_t;

  // client connection preface "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n"
  function automatic logic [7:0] preface_char(input logic [4:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'h50;
      5'd1:    c = 8'h52;
      5'd2:    c = 8'h49;
      5'd3:    c = 8'h20;
      5'd4:    c = 8'h2A;
      5'd5:    c = 8'h20;
      5'd6:    c = 8'h48;
      5'd7:    c = 8'h54;
      5'd8:    c = 8'h54;
      5'd9:    c = 8'h50;
      5'd10:   c = 8'h2F;
      5'd11:   c = 8'h32;
      5'd12:   c = 8'h2E;
      5'd13:   c = 8'h30;
      5'd14:   c = 8'h0D;
      5'd15:   c = 8'h0A;
      5'd16:   c = 8'h0D;
      5'd17:   c = 8'h0A;
      5'd18:   c = 8'h53;
      5'd19:   c = 8'h4D;
      5'd20:   c = 8'h0D;
      5'd21:   c = 8'h0A;
      5'd22:   c = 8'h0D;
      default: c = 8'h0A;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/http2_frame_deframer_flow_control_top.sv */
// Top level of the HTTP/2 receive deframer with connection flow control.
// Instantiates http2d_in_reg and http2d_core; uses http2d_pkg types.
//
// Usage:
//   in_*  : one received byte per word (valid/ready).
//   out_* : one result word per input byte: kind, payload byte, frame end,
//           current header fields, window-update increment, error code.
//   cfg_* : register writes (index 0 max frame size, 1 initial window, which
//           also reloads the window, 2 expect preface). cfg_ready is always
//           high; write only while no byte is in flight.
// Pipeline: a byte is registered in the input register at acceptance, and its
//   result in the result register once the core takes it; one byte per cycle
//   is sustained while out_ready is high. The per-byte work is a header compare
//   or a window subtract and compare between the input and result registers.
// Reset: rst_n low clears the pipeline, loads register defaults (16384,
//   65535, preface expected) and starts in preface check.
// Stall: while out_ready is low the result holds; the input register still
//   takes one more byte, then in_ready drops until the result drains.
`default_nettype none

module http2_frame_deframer_flow_control_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_frame_end,
  output logic [23:0]      out_frm_length,
  output logic [7:0]       out_frame_kind,
  output logic [7:0]       out_frame_flag_bits,
  output logic [30:0]      out_stream_number,
  output logic [30:0]      out_win_update,
  output logic [1:0]       out_fault_code,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  logic                hold_valid;
  logic [7:0]          hold_byte;
  logic                take;
  http2d_pkg::cfg_wr_t cfg;
  http2d_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  http2d_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (take)
  );

  http2d_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (take),
    .cfg        (cfg),
    .res_valid  (out_valid),
    .res        (res),
    .res_ready  (out_ready)
  );

  // unpack the result word
  assign out_kind             = res.kind;
  assign out_payload_byte     = res.payload_byte;
  assign out_frame_end        = res.frame_end;
  assign out_frm_length       = res.frm_length;
  assign out_frame_kind       = res.frame_kind;
  assign out_frame_flag_bits  = res.frame_flag_bits;
  assign out_stream_number    = res.stream_number;
  assign out_win_update       = res.win_update;
  assign out_fault_code       = res.fault_code;

endmodule

`default_nettype wire

/* rtl/http2d_in_reg.sv */
// Input register stage of the deframer: holds one received byte word.
// Depends on http2d_pkg only through the top level wiring (no package items used).
`default_nettype none

module http2d_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            hold_valid,
  output logic [7:0]      hold_byte,
  input  wire logic       take
);

  logic       valid_r;
  logic [7:0] byte_r;

  // accept a new word whenever the held one is empty or leaves this cycle
  assign in_ready   = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // payload register: load on accept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

/* rtl/http2d_core.sv */
// Deframer state machine, flow-control window and result register.
// Depends on http2d_pkg (codes, result and config word types, preface table).
`default_nettype none

module http2d_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 hold_valid,
  input  wire logic [7:0]           hold_byte,
  output logic                      take,
  input  wire http2d_pkg::cfg_wr_t  cfg,
  output logic                      res_valid,
  output http2d_pkg::result_t       res,
  input  wire logic                 res_ready
);

  typedef enum logic [1:0] {
    PH_PREFACE = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                match_r, match_nxt;
  logic [23:0]         len_r, len_nxt;
  logic [7:0]          type_r, type_nxt;
  logic [7:0]          flags_r, flags_nxt;
  logic [30:0]         stream_r, stream_nxt;
  logic [23:0]         left_r, left_nxt;
  logic [30:0]         win_r, win_nxt;
  logic                started_r, started_nxt;
  http2d_pkg::err_t    err_r, err_nxt;
  logic [23:0]         max_frame_r, max_frame_nxt;
  logic [30:0]         init_win_r, init_win_nxt;
  logic                expect_pre_r, expect_pre_nxt;
  logic                out_v_r, out_v_nxt;
  http2d_pkg::result_t res_r, res_nxt;

  logic [30:0]         len_ext;
  logic [30:0]         win_debit;
  logic                match_now;

  // process the held word when the result register is free or drains
  assign take      = hold_valid && (!out_v_r || res_ready);
  assign res_valid = out_v_r;
  assign res       = res_r;

  assign len_ext   = {7'd0, len_r};
  assign win_debit = (win_r >= len_ext) ? (win_r - len_ext) : 31'd0;
  assign match_now = match_r && (http2d_pkg::preface_char(cnt_r) == hold_byte);

  always_comb begin
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    match_nxt      = match_r;
    len_nxt        = len_r;
    type_nxt       = type_r;
    flags_nxt      = flags_r;
    stream_nxt     = stream_r;
    left_nxt       = left_r;
    win_nxt        = win_r;
    started_nxt    = started_r;
    err_nxt        = err_r;
    max_frame_nxt  = max_frame_r;
    init_win_nxt   = init_win_r;
    expect_pre_nxt = expect_pre_r;
    out_v_nxt      = out_v_r && !res_ready;
    res_nxt        = res_r;

    // step one byte
    if (take) begin
      started_nxt          = 1'b1;
      out_v_nxt            = 1'b1;
      res_nxt              = '0;
      res_nxt.kind         = http2d_pkg::KIND_ABSORB;
      res_nxt.fault_code   = http2d_pkg::ERR_NONE;
      case (phase_r)
        PH_PREFACE: begin
          match_nxt = match_now;
          cnt_nxt   = cnt_r + 5'd1;
          if (cnt_r == 5'(http2d_pkg::PREFACE_LEN - 1)) begin
            cnt_nxt   = '0;
            match_nxt = 1'b1;
            if (match_now) begin
              phase_nxt    = PH_HEADER;
              res_nxt.kind = http2d_pkg::KIND_PREFACE;
            end else begin
              phase_nxt          = PH_ERROR;
              err_nxt            = http2d_pkg::ERR_PREFACE;
              res_nxt.kind       = http2d_pkg::KIND_ERROR;
              res_nxt.fault_code = http2d_pkg::ERR_PREFACE;
            end
          end
        end
        PH_HEADER: begin
          case (cnt_r)
            5'd0:    len_nxt = {hold_byte, 16'd0};
            5'd1:    len_nxt = {len_r[23:16], hold_byte, len_r[7:0]};
            5'd2:    len_nxt = {len_r[23:8], hold_byte};
            5'd3:    type_nxt = hold_byte;
            5'd4:    flags_nxt = hold_byte;
            5'd5:    stream_nxt = {hold_byte[6:0], 24'd0};
            5'd6:    stream_nxt = {stream_r[30:24], hold_byte, stream_r[15:0]};
            5'd7:    stream_nxt = {stream_r[30:16], hold_byte, stream_r[7:0]};
            default: stream_nxt = {stream_r[30:8], hold_byte};
          endcase
          cnt_nxt = cnt_r + 5'd1;
          // header complete: length, type and flags are settled already
          if (cnt_r == 5'(http2d_pkg::HEADER_LEN - 1)) begin
            cnt_nxt = '0;
            if (len_r == 24'd0) begin
              if (type_r == http2d_pkg::TYPE_SETTINGS &&
                  (flags_r & http2d_pkg::FLAG_ACK) != 8'd0) begin
                res_nxt.kind = http2d_pkg::KIND_ACK;
              end else begin
                phase_nxt          = PH_ERROR;
                err_nxt            = http2d_pkg::ERR_FRAME;
                res_nxt.kind       = http2d_pkg::KIND_ERROR;
                res_nxt.fault_code = http2d_pkg::ERR_FRAME;
              end
            end else if (len_r > max_frame_r) begin
              phase_nxt          = PH_ERROR;
              err_nxt            = http2d_pkg::ERR_FRAME;
              res_nxt.kind       = http2d_pkg::KIND_ERROR;
              res_nxt.fault_code = http2d_pkg::ERR_FRAME;
            end else if (type_r == http2d_pkg::TYPE_DATA && len_ext > win_r) begin
              phase_nxt          = PH_ERROR;
              err_nxt            = http2d_pkg::ERR_FLOW;
              res_nxt.kind       = http2d_pkg::KIND_ERROR;
              res_nxt.fault_code = http2d_pkg::ERR_FLOW;
            end else begin
              left_nxt     = len_r;
              phase_nxt    = PH_PAYLOAD;
              res_nxt.kind = http2d_pkg::KIND_HEADER;
            end
          end
        end
        PH_PAYLOAD: begin
          res_nxt.kind         = http2d_pkg::KIND_PAYLOAD;
          res_nxt.payload_byte = hold_byte;
          left_nxt             = (left_r != 24'd0) ? left_r - 24'd1 : 24'd0;
          // last byte: close frame; on DATA debit the window, refill it at half or below
          if (left_r <= 24'd1) begin
            res_nxt.frame_end = 1'b1;
            phase_nxt         = PH_HEADER;
            if (type_r == http2d_pkg::TYPE_DATA) begin
              win_nxt = win_debit;
              if (win_debit <= (init_win_r >> 1)) begin
                res_nxt.win_update = init_win_r - win_debit;
                win_nxt            = init_win_r;
              end
            end
          end
        end
        default: begin
          res_nxt.kind       = http2d_pkg::KIND_DROP;
          res_nxt.fault_code = err_r;
        end
      endcase
      res_nxt.frm_length      = len_nxt;
      res_nxt.frame_kind      = type_nxt;
      res_nxt.frame_flag_bits = flags_nxt;
      res_nxt.stream_number   = stream_nxt;
    end

    // register writes must arrive only while idle; the block itself does not enforce it
    if (cfg.valid) begin
      case (cfg.index)
        http2d_pkg::CFG_MAX_FRAME: begin
          max_frame_nxt = cfg.data[23:0];
        end
        http2d_pkg::CFG_INIT_WINDOW: begin
          init_win_nxt = cfg.data;
          win_nxt      = cfg.data;
        end
        http2d_pkg::CFG_EXPECT_PRE: begin
          expect_pre_nxt = cfg.data[0];
          if (!started_r) begin
            phase_nxt = cfg.data[0] ? PH_PREFACE : PH_HEADER;
            cnt_nxt   = '0;
            match_nxt = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // hold state, configuration and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PREFACE;
      cnt_r        <= '0;
      match_r      <= 1'b1;
      len_r        <= '0;
      type_r       <= '0;
      flags_r      <= '0;
      stream_r     <= '0;
      left_r       <= '0;
      win_r        <= http2d_pkg::INIT_WINDOW_RST;
      started_r    <= 1'b0;
      err_r        <= http2d_pkg::ERR_NONE;
      max_frame_r  <= http2d_pkg::MAX_FRAME_RST;
      init_win_r   <= http2d_pkg::INIT_WINDOW_RST;
      expect_pre_r <= 1'b1;
      out_v_r      <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      match_r      <= match_nxt;
      len_r        <= len_nxt;
      type_r       <= type_nxt;
      flags_r      <= flags_nxt;
      stream_r     <= stream_nxt;
      left_r       <= left_nxt;
      win_r        <= win_nxt;
      started_r    <= started_nxt;
      err_r        <= err_nxt;
      max_frame_r  <= max_frame_nxt;
      init_win_r   <= init_win_nxt;
      expect_pre_r <= expect_pre_nxt;
      out_v_r      <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // counters stay inside their phase's range
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_HEADER || cnt_r < 5'(http2d_pkg::HEADER_LEN)) &&
    (phase_r != PH_PREFACE || cnt_r < 5'(http2d_pkg::PREFACE_LEN)))
    else $error("byte counter out of range");

  // no payload outstanding outside the payload phase
  a_left_idle: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_PAYLOAD |-> left_r == 24'd0)
    else $error("payload count left over outside payload phase");

  // error and drop results carry a code
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && (res_r.kind == http2d_pkg::KIND_ERROR ||
                res_r.kind == http2d_pkg::KIND_DROP)
    |-> res_r.fault_code != http2d_pkg::ERR_NONE)
    else $error("error result without code");

  // window updates only close a DATA payload
  a_win_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && res_r.win_update != 31'd0
    |-> res_r.frame_end && res_r.kind == http2d_pkg::KIND_PAYLOAD &&
        res_r.frame_kind == http2d_pkg::TYPE_DATA)
    else $error("window update outside frame end");

  // the error phase is sticky
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_ERROR |=> phase_r == PH_ERROR)
    else $error("left error phase without reset");

endmodule

`default_nettype wire
